[hdl/oldest_slot_replacement_unit_defines.svh]
// Assertion macros shared by the slot replacement unit modules.
// No dependencies. Every macro samples on clock and is disabled in reset.
`ifndef OLDEST_SLOT_REPLACEMENT_UNIT_DEFINES_SVH
`define OLDEST_SLOT_REPLACEMENT_UNIT_DEFINES_SVH

// ante true at an edge -> cons true at the same edge
`define OSR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// ante true at an edge -> cons true at the following edge
`define OSR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/osr_pkg.sv]
// Shared types and constants for the oldest slot replacement unit.
// No dependencies.
package osr_pkg;

   localparam int NUM_SLOTS  = 16;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
   localparam int STAMP_W    = 32;
   localparam int CFG_W      = 5;
   localparam int RSP_IDX_W  = 4;
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } osr_state_type;

   typedef struct packed {
      logic init;    // load timestamp, clear scan accumulators
      logic scan;    // examine one slot
      logic commit;  // write chosen slot, issue result
   } osr_cmd_type;

   typedef struct packed {
      logic scan_last;  // slot under scan is the last active one
   } osr_status_type;

endpackage

[hdl/oldest_slot_replacement_unit.sv]
// Top level of the oldest slot replacement unit: controller plus datapath.
// Depends on osr_pkg, osr_ctrl and osr_dpath.
//
//   channel   ports                                  transfer when
//   -------   ------------------------------------   ------------------------
//   request   start, busy, req_msg_time              start && !busy
//   result    rsp_valid, rsp_slot_index, rsp_evicted rsp_valid (one cycle)
//   csr       csr_valid, csr_ready, csr_data         csr_valid && csr_ready
//
// A request scans the active slots one per cycle, up to the saturated slot
// limit (1 .. 16): busy is high from the accepting edge through the scan and commit
// states, so a new request is taken only once the unit is idle again.
// rsp_valid is high for a single cycle, registered from the commit state.
// Synchronous active-high reset clears all valid marks and sets the limit to 16.
// The receiver cannot stall; csr_ready is high whenever the unit is idle.

module oldest_slot_replacement_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          start,
   output logic                          busy,
   input  logic [osr_pkg::STAMP_W-1:0]   req_msg_time,
   // result
   output logic                          rsp_valid,
   output logic [osr_pkg::RSP_IDX_W-1:0] rsp_slot_index,
   output logic                          rsp_evicted,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [osr_pkg::CFG_W-1:0]     csr_data
);
   import osr_pkg::*;

   osr_cmd_type    cmd;
   osr_status_type status;

   // limit only changes between requests
   assign csr_ready = !busy;

   osr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   osr_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_valid && csr_ready),
      .csr_data       (csr_data),
      .msg_time       (req_msg_time),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_slot_index (rsp_slot_index),
      .rsp_evicted    (rsp_evicted)
   );

endmodule

[hdl/osr_ctrl.sv]
// Sequencer for the slot replacement unit: idle, scan, commit.
// Depends on osr_pkg and oldest_slot_replacement_unit_defines.svh.
`include "oldest_slot_replacement_unit_defines.svh"

module osr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  osr_pkg::osr_status_type status,
   output osr_pkg::osr_cmd_type    cmd
);
   import osr_pkg::*;

   osr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.init = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `OSR_ASSERT_NEXT(a_start_to_scan, start && !busy, state_ff == ST_SCAN, "start not taken")
   `OSR_ASSERT_NEXT(a_commit_once, state_ff == ST_COMMIT, state_ff == ST_IDLE, "commit repeated")

endmodule

[hdl/osr_dpath.sv]
// Datapath: slot table, limit register, one-slot-per-cycle scan, result register.
// Depends on osr_pkg and oldest_slot_replacement_unit_defines.svh.
`include "oldest_slot_replacement_unit_defines.svh"

module osr_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [osr_pkg::CFG_W-1:0]     csr_data,
   input  logic [osr_pkg::STAMP_W-1:0]   msg_time,
   input  osr_pkg::osr_cmd_type          cmd,
   output osr_pkg::osr_status_type       status,
   output logic                          rsp_valid,
   output logic [osr_pkg::RSP_IDX_W-1:0] rsp_slot_index,
   output logic                          rsp_evicted
);
   import osr_pkg::*;

   logic [CFG_W-1:0]   limit_ff;
   logic [NUM_SLOTS-1:0] slot_valid_ff;
   logic [STAMP_W-1:0] slot_stamp_ff [NUM_SLOTS];

   logic [STAMP_W-1:0] time_ff;
   logic [SLOT_W-1:0]  idx_ff;
   logic               free_found_ff;
   logic [SLOT_W-1:0]  free_idx_ff;
   logic [STAMP_W-1:0] best_ff;
   logic [SLOT_W-1:0]  best_idx_ff;

   logic               rsp_valid_ff;
   logic [RSP_IDX_W-1:0] rsp_slot_index_ff;
   logic               rsp_evicted_ff;

   logic [CNT_W-1:0]   eff_limit;
   logic [SLOT_W-1:0]  last_idx;
   logic [SLOT_W-1:0]  pick;
   logic [STAMP_W-1:0] cur_stamp;
   logic               take_best;

   // limit saturated to 1 .. NUM_SLOTS
   always_comb begin
      if (limit_ff == '0) begin
         eff_limit = CNT_W'(1);
      end else if (int'(limit_ff) > NUM_SLOTS) begin
         eff_limit = CNT_W'(NUM_SLOTS);
      end else begin
         eff_limit = CNT_W'(limit_ff);
      end
   end

   assign last_idx         = SLOT_W'(eff_limit - CNT_W'(1));
   assign status.scan_last = (idx_ff == last_idx);
   assign cur_stamp        = slot_stamp_ff[idx_ff];
   assign take_best        = (idx_ff == '0) || (cur_stamp < best_ff);
   assign pick             = free_found_ff ? free_idx_ff : best_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CFG_RESET;
      end else if (csr_write) begin
         limit_ff <= csr_data;
      end
   end

   // scan accumulators
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         time_ff       <= msg_time;
         idx_ff        <= '0;
         free_found_ff <= 1'b0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + SLOT_W'(1);
         if (!slot_valid_ff[idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= idx_ff;
         end
         if (take_best) begin
            best_ff     <= cur_stamp;
            best_idx_ff <= idx_ff;
         end
      end
   end

   // slot table; stamps reach the result only when every scanned slot is valid, so they need no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (cmd.commit) begin
         slot_valid_ff[pick] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         slot_stamp_ff[pick] <= time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_slot_index_ff <= RSP_IDX_W'(pick);
         rsp_evicted_ff    <= !free_found_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_index_ff;
   assign rsp_evicted    = rsp_evicted_ff;

   `OSR_ASSERT_SAME(a_scan_in_range, cmd.scan, idx_ff <= last_idx, "scan past limit")
   `OSR_ASSERT_NEXT(a_rsp_single, rsp_valid_ff, !rsp_valid_ff, "result strobe too long")
   `OSR_ASSERT_SAME(a_evict_only_full, cmd.commit && !free_found_ff, slot_valid_ff[best_idx_ff], "evicting a free slot")

endmodule
